// ----- hw/rtl/iep_pkg.sv -----
package iep_pkg;

    localparam int BANDS      = 16;
    localparam int MAX_DIM    = 4096;
    localparam int DIM_W      = $clog2(MAX_DIM);
    localparam int BAND_W     = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int FIFO_DEPTH = 4;

    typedef enum logic [2:0] {
        REG_ALPHA_FLOOR     = 3'd0,
        REG_PEN_X           = 3'd1,
        REG_BASELINE_Y      = 3'd2,
        REG_INV_EM_PX       = 3'd3,
        REG_BAND_BOTTOM_EM  = 3'd4,
        REG_INV_BAND_HEIGHT = 3'd5,
        REG_ADVANCE_EM      = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic signed [23:0] pen_x;
        logic signed [23:0] baseline_y;
        logic [23:0]        inv_em_px;
        logic signed [23:0] band_bottom_em;
        logic [23:0]        inv_band_height;
        logic [22:0]        advance_em;
    } cfg_t;

    typedef struct packed {
        logic             inked;
        logic             frame;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] first_col;
        logic [DIM_W-1:0] last_col;
        logic [7:0]       first_alpha;
        logic [7:0]       last_alpha;
    } row_rec_t;

endpackage

// ----- hw/rtl/iep_fifo.sv -----
module iep_fifo
    import iep_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  row_rec_t push_data,
    output logic     full,
    input  logic     pop,
    output logic     not_empty,
    output row_rec_t pop_data
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    row_rec_t           mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     count_reg;

    assign full      = (count_reg == (PTR_W + 1)'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/iep_front.sv -----
module iep_front
    import iep_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] alpha_floor,
    input  logic       accept,
    input  logic [7:0] alpha,
    input  logic       row_end,
    input  logic       frame_end,
    output logic       push,
    output row_rec_t   push_data
);

    localparam logic [DIM_W-1:0] DIM_LAST = DIM_W'(MAX_DIM - 1);

    logic [DIM_W-1:0] col_reg;
    logic [DIM_W-1:0] row_reg;
    logic [DIM_W-1:0] first_col_reg;
    logic [DIM_W-1:0] last_col_reg;
    logic [7:0]       first_alpha_reg;
    logic [7:0]       last_alpha_reg;
    logic             inked_reg;
    logic             ink;
    logic             ends_row;

    assign ink      = (alpha >= alpha_floor);
    assign ends_row = row_end || frame_end;
    assign push     = accept && ends_row;

    always_comb begin
        push_data.inked       = inked_reg || ink;
        push_data.frame       = frame_end;
        push_data.row         = row_reg;
        push_data.first_col   = inked_reg ? first_col_reg : col_reg;
        push_data.first_alpha = inked_reg ? first_alpha_reg : alpha;
        push_data.last_col    = ink ? col_reg : last_col_reg;
        push_data.last_alpha  = ink ? alpha : last_alpha_reg;
        if (!(inked_reg || ink)) begin
            push_data.first_col   = '0;
            push_data.first_alpha = '0;
            push_data.last_col    = '0;
            push_data.last_alpha  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg         <= '0;
            row_reg         <= '0;
            first_col_reg   <= '0;
            last_col_reg    <= '0;
            first_alpha_reg <= '0;
            last_alpha_reg  <= '0;
            inked_reg       <= 1'b0;
        end else if (accept) begin
            if (ends_row) begin
                col_reg         <= '0;
                inked_reg       <= 1'b0;
                first_col_reg   <= '0;
                last_col_reg    <= '0;
                first_alpha_reg <= '0;
                last_alpha_reg  <= '0;
                if (frame_end) begin
                    row_reg <= '0;
                end else if (row_reg != DIM_LAST) begin
                    row_reg <= row_reg + 1'b1;
                end
            end else begin
                if (col_reg != DIM_LAST) begin
                    col_reg <= col_reg + 1'b1;
                end
                if (ink) begin
                    if (!inked_reg) begin
                        first_col_reg   <= col_reg;
                        first_alpha_reg <= alpha;
                    end
                    last_col_reg   <= col_reg;
                    last_alpha_reg <= alpha;
                    inked_reg      <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- hw/rtl/iep_back.sv -----
module iep_back
    import iep_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               rec_valid,
    input  row_rec_t           rec,
    output logic               rec_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [4:0]         m_band_index,
    output logic               m_band_has_ink,
    output logic signed [23:0] m_left_em,
    output logic signed [23:0] m_right_em,
    output logic               m_top_valid,
    output logic signed [23:0] m_top_em,
    output logic [22:0]        m_advance_out,
    output logic               m_last
);

    localparam logic signed [51:0] CLAMP_LO  = -52'sd2139095040;
    localparam logic signed [51:0] CLAMP_HI  = 52'sd2139095039;
    localparam logic signed [51:0] SAT_HI    = 52'sd8388607;
    localparam logic signed [51:0] SAT_LO    = -52'sd8388608;
    localparam logic [35:0]        RECIP_255 = 36'd4311810306;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_YC, S_BAND, S_LDIV, S_LQ, S_RDIV, S_RQ, S_TOP, S_EMIT
    } state_t;

    state_t                 state_reg;
    state_t                 ret_reg;
    row_rec_t               rec_reg;
    logic signed [35:0]     x_reg;
    logic [35:0]            y_reg;
    logic [1:0]             k_reg;
    logic [1:0]             nch_reg;
    logic signed [67:0]     acc_reg;
    logic [BAND_W-1:0]      band_reg;
    logic [BAND_W-1:0]      idx_reg;

    logic [BANDS-1:0]       valid_reg;
    logic signed [23:0]     left_mem  [BANDS];
    logic signed [23:0]     right_mem [BANDS];
    logic signed [23:0]     top_reg;
    logic                   top_seen_reg;

    logic [11:0]            chunk;
    logic signed [48:0]     prod;
    logic signed [67:0]     acc_add;
    logic signed [35:0]     d_center;
    logic signed [35:0]     d_top;
    logic signed [35:0]     t_left;
    logic signed [35:0]     t_right;
    logic signed [35:0]     n_left;
    logic signed [35:0]     n_right;
    logic signed [35:0]     alpha_l;
    logic signed [35:0]     alpha_r;
    logic signed [35:0]     pen36;
    logic signed [35:0]     base36;
    logic signed [35:0]     yc;
    logic signed [35:0]     band_hi;
    logic signed [51:0]     m_div;
    logic signed [51:0]     m_clamp;
    logic [31:0]            u_div;
    logic signed [23:0]     q_edge;
    logic signed [51:0]     top_wide;
    logic signed [23:0]     top_sat;
    logic [BAND_W-1:0]      rd_addr;
    logic                   rd_valid;
    logic signed [23:0]     rd_left;
    logic signed [23:0]     rd_right;
    logic                   out_load;
    logic [DIM_W:0]         c1;

    always_comb begin
        unique case (k_reg)
            2'd0:    chunk = y_reg[11:0];
            2'd1:    chunk = y_reg[23:12];
            default: chunk = y_reg[35:24];
        endcase
    end

    assign prod = x_reg * $signed({1'b0, chunk});

    always_comb begin
        unique case (k_reg)
            2'd0:    acc_add = acc_reg + 68'(prod);
            2'd1:    acc_add = acc_reg + (68'(prod) <<< 12);
            default: acc_add = acc_reg + (68'(prod) <<< 24);
        endcase
    end

    assign pen36    = 36'($signed(cfg.pen_x));
    assign base36   = 36'($signed(cfg.baseline_y));
    assign d_center = base36 - $signed({{(28 - DIM_W){1'b0}}, rec_reg.row, 8'd128});
    assign d_top    = base36 - $signed({{(28 - DIM_W){1'b0}}, rec_reg.row, 8'd0});
    assign c1       = {1'b0, rec_reg.first_col} + 1'b1;
    assign t_left   = $signed({{(27 - DIM_W){1'b0}}, c1, 8'd0}) - pen36;
    assign t_right  = $signed({{(28 - DIM_W){1'b0}}, rec_reg.last_col, 8'd0}) - pen36;
    assign alpha_l  = $signed({20'd0, rec_reg.first_alpha, 8'd0});
    assign alpha_r  = $signed({20'd0, rec_reg.last_alpha, 8'd0});
    assign n_left   = (t_left <<< 8) - t_left - alpha_l;
    assign n_right  = (t_right <<< 8) - t_right + alpha_r;

    assign yc       = 36'((acc_reg + 68'sd32768) >>> 16);
    assign band_hi  = 36'(acc_reg >>> 32);
    assign m_div    = 52'((acc_reg + 68'sd8355840) >>> 16);
    assign m_clamp  = (m_div < CLAMP_LO) ? CLAMP_LO : (m_div > CLAMP_HI) ? CLAMP_HI : m_div;
    assign u_div    = 32'(m_clamp - CLAMP_LO);
    assign q_edge   = {~acc_reg[63], acc_reg[62:40]};
    assign top_wide = 52'((acc_reg + 68'sd32768) >>> 16);
    assign top_sat  = (top_wide > SAT_HI) ? 24'sh7FFFFF :
                      (top_wide < SAT_LO) ? 24'sh800000 : 24'(top_wide);

    assign rd_addr  = (state_reg == S_EMIT) ? idx_reg : band_reg;
    assign rd_valid = valid_reg[rd_addr];
    assign rd_left  = left_mem[rd_addr];
    assign rd_right = right_mem[rd_addr];

    assign rec_pop  = (state_reg == S_IDLE) && rec_valid;
    assign out_load = (state_reg == S_EMIT) && (!m_valid || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ret_reg      <= S_IDLE;
            k_reg        <= '0;
            nch_reg      <= '0;
            idx_reg      <= '0;
            valid_reg    <= '0;
            top_reg      <= '0;
            top_seen_reg <= 1'b0;
            m_valid      <= 1'b0;
        end else begin
            if (m_ready && !out_load) begin
                m_valid <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (rec_valid) begin
                        rec_reg <= rec;
                        idx_reg <= '0;
                        if (rec.inked) begin
                            x_reg     <= 36'sd0;
                            y_reg     <= '0;
                            acc_reg   <= '0;
                            k_reg     <= '0;
                            nch_reg   <= 2'd1;
                            state_reg <= S_YC;
                        end else if (rec.frame) begin
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_YC: begin
                    if (nch_reg == 2'd1 && y_reg == '0) begin
                        x_reg   <= d_center;
                        acc_reg <= '0;
                        k_reg   <= '0;
                        nch_reg <= 2'd1;
                        ret_reg <= S_YC;
                        y_reg   <= {12'd1, cfg.inv_em_px};
                        state_reg <= S_MUL;
                    end else begin
                        x_reg     <= yc - 36'($signed(cfg.band_bottom_em));
                        y_reg     <= {12'd0, cfg.inv_band_height};
                        acc_reg   <= '0;
                        k_reg     <= '0;
                        nch_reg   <= 2'd1;
                        ret_reg   <= S_BAND;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    acc_reg <= acc_add;
                    if (k_reg == nch_reg) begin
                        state_reg <= ret_reg;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                S_BAND: begin
                    if (band_hi >= 36'sd0 && band_hi < 36'(BANDS)) begin
                        band_reg  <= BAND_W'(band_hi);
                        x_reg     <= n_left;
                        y_reg     <= {12'd0, cfg.inv_em_px};
                        acc_reg   <= '0;
                        k_reg     <= '0;
                        nch_reg   <= 2'd1;
                        ret_reg   <= S_LDIV;
                        state_reg <= S_MUL;
                    end else begin
                        state_reg <= rec_reg.frame ? S_EMIT : S_IDLE;
                    end
                end
                S_LDIV, S_RDIV: begin
                    x_reg     <= $signed({4'd0, u_div});
                    y_reg     <= RECIP_255;
                    acc_reg   <= '0;
                    k_reg     <= '0;
                    nch_reg   <= 2'd2;
                    ret_reg   <= (state_reg == S_LDIV) ? S_LQ : S_RQ;
                    state_reg <= S_MUL;
                end
                S_LQ, S_RQ: begin
                    if (!rd_valid || q_edge < rd_left) begin
                        left_mem[band_reg] <= q_edge;
                    end
                    if (!rd_valid || q_edge > rd_right) begin
                        right_mem[band_reg] <= q_edge;
                    end
                    valid_reg[band_reg] <= 1'b1;
                    x_reg     <= (state_reg == S_LQ) ? n_right : d_top;
                    y_reg     <= {12'd0, cfg.inv_em_px};
                    acc_reg   <= '0;
                    k_reg     <= '0;
                    nch_reg   <= 2'd1;
                    ret_reg   <= (state_reg == S_LQ) ? S_RDIV : S_TOP;
                    state_reg <= S_MUL;
                end
                S_TOP: begin
                    if (!top_seen_reg || top_sat > top_reg) begin
                        top_reg <= top_sat;
                    end
                    top_seen_reg <= 1'b1;
                    state_reg    <= rec_reg.frame ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (out_load) begin
                        m_valid        <= 1'b1;
                        m_band_index   <= 5'(idx_reg);
                        m_band_has_ink <= rd_valid;
                        m_left_em      <= rd_valid ? rd_left : 24'sd0;
                        m_right_em     <= rd_valid ? rd_right : 24'sd0;
                        m_top_valid    <= top_seen_reg;
                        m_top_em       <= top_seen_reg ? top_reg : 24'sd0;
                        m_advance_out  <= cfg.advance_em;
                        m_last         <= (idx_reg == BAND_W'(BANDS - 1));
                        if (idx_reg == BAND_W'(BANDS - 1)) begin
                            valid_reg    <= '0;
                            top_reg      <= '0;
                            top_seen_reg <= 1'b0;
                            state_reg    <= S_IDLE;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- hw/rtl/ink_edge_profile_rows_unit.sv -----
// channel   dir  handshake          payload
// s_        in   s_valid/s_ready    s_alpha, s_row_end, s_frame_end
// m_        out  m_valid/m_ready    m_band_index .. m_last, one item per band
// cfg_      in   cfg_valid/ready    cfg_index, cfg_data
// Pixels are taken one per cycle while the four-entry row queue has room.
// Each row end is worked by the back end, on one 36x12 multiplier with two
// or three passes per product; an inked row in a band takes the most work,
// an inked row outside the bands less, and an empty row the least.
// Frame end adds one output item per band. Reset is synchronous and clears all
// control state; output stalls hold the back end while the front keeps going.
module ink_edge_profile_rows_unit
    import iep_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_alpha,
    input  logic               s_row_end,
    input  logic               s_frame_end,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [4:0]         m_band_index,
    output logic               m_band_has_ink,
    output logic signed [23:0] m_left_em,
    output logic signed [23:0] m_right_em,
    output logic               m_top_valid,
    output logic signed [23:0] m_top_em,
    output logic [22:0]        m_advance_out,
    output logic               m_last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data
);

    logic [7:0] alpha_floor_reg;
    cfg_t       cfg_reg;
    logic       accept;
    logic       push;
    row_rec_t   push_data;
    logic       fifo_full;
    logic       fifo_pop;
    logic       fifo_valid;
    row_rec_t   fifo_data;

    assign cfg_ready = 1'b1;
    assign s_ready   = !fifo_full;
    assign accept    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_floor_reg         <= 8'd8;
            cfg_reg.pen_x           <= '0;
            cfg_reg.baseline_y      <= '0;
            cfg_reg.inv_em_px       <= 24'd65536;
            cfg_reg.band_bottom_em  <= '0;
            cfg_reg.inv_band_height <= 24'd65536;
            cfg_reg.advance_em      <= 23'd65536;
        end else if (cfg_valid) begin
            unique case (reg_idx_t'(cfg_index))
                REG_ALPHA_FLOOR:     alpha_floor_reg         <= cfg_data[7:0];
                REG_PEN_X:           cfg_reg.pen_x           <= cfg_data;
                REG_BASELINE_Y:      cfg_reg.baseline_y      <= cfg_data;
                REG_INV_EM_PX:       cfg_reg.inv_em_px       <= cfg_data;
                REG_BAND_BOTTOM_EM:  cfg_reg.band_bottom_em  <= cfg_data;
                REG_INV_BAND_HEIGHT: cfg_reg.inv_band_height <= cfg_data;
                REG_ADVANCE_EM:      cfg_reg.advance_em      <= cfg_data[22:0];
                default: ;
            endcase
        end
    end

    iep_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .alpha_floor (alpha_floor_reg),
        .accept      (accept),
        .alpha       (s_alpha),
        .row_end     (s_row_end),
        .frame_end   (s_frame_end),
        .push        (push),
        .push_data   (push_data)
    );

    iep_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .not_empty (fifo_valid),
        .pop_data  (fifo_data)
    );

    iep_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .rec_valid      (fifo_valid),
        .rec            (fifo_data),
        .rec_pop        (fifo_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_band_index   (m_band_index),
        .m_band_has_ink (m_band_has_ink),
        .m_left_em      (m_left_em),
        .m_right_em     (m_right_em),
        .m_top_valid    (m_top_valid),
        .m_top_em       (m_top_em),
        .m_advance_out  (m_advance_out),
        .m_last         (m_last)
    );

    a_last_band: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_band_index == 5'(BANDS - 1))
        else $error("last item not on final band");

    a_band_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last ##1 m_valid |->
            m_band_index == $past(m_band_index) + 5'd1)
        else $error("band items out of order");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule
